>>> rtl/lcdws_pkg.sv
package lcdws_pkg;

  // request kinds carried in the slave-side tuser
  localparam logic [1:0] OpInit  = 2'd0;
  localparam logic [1:0] OpWrite = 2'd1;
  localparam logic [1:0] OpGoto  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CfgCyclesPerMs = 2'd0;
  localparam logic [1:0] CfgPulseCycles = 2'd1;
  localparam logic [1:0] CfgPowerOnMs   = 2'd2;

  // reset values of the configuration registers
  localparam logic [19:0] CyclesPerMsRst = 20'd8000;
  localparam logic [7:0]  PulseCyclesRst = 8'd8;
  localparam logic [7:0]  PowerOnMsRst   = 8'd50;

  // set-ddram-address bases for the two display lines
  localparam logic [7:0] Line0Base = 8'h80;
  localparam logic [7:0] Line1Base = 8'hC0;

  // microcode entry points
  localparam logic [2:0] UcInitPc = 3'd0;
  localparam logic [2:0] UcItemPc = 3'd7;

  typedef struct packed {
    logic       last;       // end of program, back to idle after hold-off
    logic       from_item;  // bus byte and rs come from the captured request
    logic       power_on;   // wait_before takes the power-on delay
    logic [5:0] after_ms;
    logic [7:0] bus_byte;
  } ucode_t;

  // control store: init program at 0..6, single-transfer step at 7
  function automatic ucode_t ucode_word(input logic [2:0] pc);
    ucode_t w;
    w = '{last: 1'b0, from_item: 1'b0, power_on: 1'b0, after_ms: 6'd1, bus_byte: 8'h30};
    case (pc)
      3'd0: begin
        w.power_on = 1'b1;
        w.after_ms = 6'd5;
      end
      3'd1: w.bus_byte = 8'h30;
      3'd2: w.bus_byte = 8'h30;
      3'd3: w.bus_byte = 8'h38;
      3'd4: w.bus_byte = 8'h0C;
      3'd5: w.bus_byte = 8'h01;
      3'd6: begin
        w.bus_byte = 8'h06;
        w.last     = 1'b1;
      end
      default: begin
        w.from_item = 1'b1;
        w.bus_byte  = 8'h00;
        w.last      = 1'b1;
      end
    endcase
    return w;
  endfunction

endpackage

>>> rtl/char_lcd_parallel_write_sequencer.sv
// channel | dir | handshake             | payload
// --------+-----+-----------------------+------------------------------------------
// request | in  | s_axis_tvalid/tready  | tuser opcode, tdata byte/is_data/row/col
// xfer    | out | m_axis_tvalid/tready  | tdata waits/rs/byte, tlast last transfer
// config  | in  | cfg_we_i              | cfg_idx_i selects, cfg_data_i value
//
// a request is taken only when the sequencer is idle; init yields seven words, write and
// goto one word each, opcode 3 is dropped at once
// each word is loaded from the microcode store in the load state, then waits for
// m_axis_tready, then the timer holds off through a strobe phase set by the pulse-width
// register and a hold phase set by the cycles-per-ms register before the next word or idle
// reset is asynchronous, active low; it restores the configuration register defaults and idles
// a stalled master side simply holds the word; the hold-off starts at its handshake
module char_lcd_parallel_write_sequencer (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [19:0] cfg_data_i,
  // request stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,  // byte_value[7:0], is_data[8], row[9], column[15:10]
  input  logic [1:0]  s_axis_tuser_i,  // opcode[1:0]
  // transfer stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,  // wait_before_ms[7:0], register_select[8],
                                       // bus_byte[16:9], wait_after_ms[22:17], zero[23]
  output logic        m_axis_tlast_o   // last_transfer
);

  // sequencer states
  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StLoad = 2'd1;
  localparam logic [1:0] StEmit = 2'd2;
  localparam logic [1:0] StWait = 2'd3;

  logic [1:0]  state_q, state_d;
  logic [2:0]  pc_q, pc_d;

  // configuration registers
  logic [19:0] cycles_per_ms_q;
  logic [7:0]  pulse_cycles_q;
  logic [7:0]  power_on_ms_q;

  // captured request operands
  logic [7:0]  item_byte_q, item_byte_d;
  logic        item_rs_q, item_rs_d;

  // output word register
  logic [7:0]  out_before_q;
  logic        out_rs_q;
  logic [7:0]  out_byte_q;
  logic [5:0]  out_after_q;
  logic        out_last_q;

  lcdws_pkg::ucode_t uc;
  logic        s_fire, m_fire, tmr_done;
  logic [1:0]  opcode;
  logic [7:0]  goto_base;

  assign opcode    = s_axis_tuser_i;
  assign s_fire    = s_axis_tvalid_i && s_axis_tready_o;
  assign m_fire    = m_axis_tvalid_o && m_axis_tready_i;
  assign uc        = lcdws_pkg::ucode_word(pc_q);
  assign goto_base = s_axis_tdata_i[9] ? lcdws_pkg::Line1Base : lcdws_pkg::Line0Base;

  assign s_axis_tready_o = (state_q == StIdle);
  assign m_axis_tvalid_o = (state_q == StEmit);
  assign m_axis_tdata_o  = {1'b0, out_after_q, out_byte_q, out_rs_q, out_before_q};
  assign m_axis_tlast_o  = out_last_q;

  // sequencer: dispatch on opcode, step through the control store
  always_comb begin
    state_d     = state_q;
    pc_d        = pc_q;
    item_byte_d = item_byte_q;
    item_rs_d   = item_rs_q;
    case (state_q)
      StIdle: begin
        if (s_fire) begin
          case (opcode)
            lcdws_pkg::OpInit: begin
              pc_d    = lcdws_pkg::UcInitPc;
              state_d = StLoad;
            end
            lcdws_pkg::OpWrite: begin
              pc_d        = lcdws_pkg::UcItemPc;
              item_byte_d = s_axis_tdata_i[7:0];
              item_rs_d   = s_axis_tdata_i[8];
              state_d     = StLoad;
            end
            lcdws_pkg::OpGoto: begin
              pc_d        = lcdws_pkg::UcItemPc;
              item_byte_d = goto_base + {2'b00, s_axis_tdata_i[15:10]};
              item_rs_d   = 1'b0;
              state_d     = StLoad;
            end
            default: state_d = StIdle;  // unused opcode, dropped
          endcase
        end
      end
      StLoad: state_d = StEmit;
      StEmit: begin
        if (m_fire) state_d = StWait;
      end
      StWait: begin
        if (tmr_done) begin
          if (uc.last) begin
            state_d = StIdle;
          end else begin
            pc_d    = pc_q + 3'd1;
            state_d = StLoad;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      pc_q    <= lcdws_pkg::UcInitPc;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
    end
  end

  // configuration writes, out-of-range index ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cycles_per_ms_q <= lcdws_pkg::CyclesPerMsRst;
      pulse_cycles_q  <= lcdws_pkg::PulseCyclesRst;
      power_on_ms_q   <= lcdws_pkg::PowerOnMsRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lcdws_pkg::CfgCyclesPerMs: cycles_per_ms_q <= cfg_data_i;
        lcdws_pkg::CfgPulseCycles: pulse_cycles_q  <= cfg_data_i[7:0];
        lcdws_pkg::CfgPowerOnMs:   power_on_ms_q   <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // payload registers: request operands and the word being offered
  always_ff @(posedge clk_i) begin
    item_byte_q <= item_byte_d;
    item_rs_q   <= item_rs_d;
    if (state_q == StLoad) begin
      out_before_q <= uc.power_on ? power_on_ms_q : 8'd0;
      out_rs_q     <= uc.from_item ? item_rs_q : 1'b0;
      out_byte_q   <= uc.from_item ? item_byte_q : uc.bus_byte;
      out_after_q  <= uc.after_ms;
      out_last_q   <= uc.last;
    end
  end

  // strobe width plus one millisecond of hold-off after each word
  lcdws_holdoff u_holdoff (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (m_fire),
    .pulse_cycles_i  (pulse_cycles_q),
    .cycles_per_ms_i (cycles_per_ms_q),
    .done_o          (tmr_done)
  );

`ifndef SYNTH
  a_one_side_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> !m_axis_tvalid_o)
    else $error("request taken while a word is pending");
  a_holdoff_after_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_fire |=> (!m_axis_tvalid_o && (state_q == StWait)))
    else $error("no hold-off after a word");
  a_last_at_program_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tlast_o) |-> (pc_q == 3'd6 || pc_q == lcdws_pkg::UcItemPc))
    else $error("tlast outside a program end");
  a_done_only_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tmr_done |-> (state_q == StWait))
    else $error("hold-off finished outside the wait state");
`endif

endmodule

>>> rtl/lcdws_holdoff.sv
module lcdws_holdoff (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [7:0]  pulse_cycles_i,
  input  logic [19:0] cycles_per_ms_i,
  output logic        done_o
);

  localparam logic [1:0] PhIdle   = 2'd0;
  localparam logic [1:0] PhStrobe = 2'd1;
  localparam logic [1:0] PhHold   = 2'd2;

  logic [1:0]  phase_q, phase_d;
  logic [19:0] cnt_q, cnt_d;
  logic        cnt_end;

  assign cnt_end = (cnt_q <= 20'd1);
  assign done_o  = (phase_q == PhHold) && cnt_end;

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    case (phase_q)
      PhIdle: begin
        if (start_i) begin
          phase_d = PhStrobe;
          cnt_d   = {12'd0, pulse_cycles_i};
        end
      end
      PhStrobe: begin
        if (cnt_end) begin
          phase_d = PhHold;
          cnt_d   = cycles_per_ms_i;
        end else begin
          cnt_d = cnt_q - 20'd1;
        end
      end
      PhHold: begin
        if (cnt_end) begin
          phase_d = PhIdle;
        end else begin
          cnt_d = cnt_q - 20'd1;
        end
      end
      default: phase_d = PhIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      cnt_q   <= 20'd0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
    end
  end

`ifndef SYNTH
  a_start_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> (phase_q == PhIdle))
    else $error("hold-off restarted while running");
  a_done_then_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> (phase_q == PhIdle))
    else $error("hold-off did not return to idle");
  a_strobe_to_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhStrobe && cnt_end) |=> (phase_q == PhHold))
    else $error("strobe did not hand over to hold");
`endif

endmodule

>>> verif/char_lcd_parallel_write_sequencer_tb.sv
`timescale 1ns / 1ps

module char_lcd_parallel_write_sequencer_tb;

  // unused register index, writes to it must be dropped
  localparam logic [1:0] CfgUnused = 2'd3;
  localparam logic [1:0] OpUnused  = 2'd3;

  // run length guard, far above the slowest legal run
  localparam int unsigned CycleLimit = 2000000;
  // receiver backpressure: one long hold-off after this many words
  localparam int unsigned LongHoldAt     = 60;
  localparam int unsigned LongHoldCycles = 400;
  // cap on the quiet time before the verdict
  localparam int unsigned EndWaitMax = 2000;

  // what the sender does next
  typedef enum logic [1:0] {
    StepReq,
    StepCfg,
    StepDrain
  } step_kind_e;

  typedef struct packed {
    step_kind_e kind;
    logic [1:0] opcode;
    logic [7:0] byte_value;
    logic       is_data;
    logic       row;
    logic [5:0] column;
    logic [1:0] cfg_idx;
    logic [19:0] cfg_val;
    logic [1:0] gap;
  } step_t;

  // one bus transfer as the block reports it
  typedef struct packed {
    logic [7:0] wait_before;
    logic       rs;
    logic [7:0] bus;
    logic [5:0] wait_after;
    logic       last;
  } xfer_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_idx = '0;
  logic [19:0] cfg_data = '0;
  logic        s_valid = 1'b0;
  logic [15:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tready = 1'b0;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [23:0] m_axis_tdata_o;
  logic        m_axis_tlast_o;

  // shadow of the configuration registers
  logic [19:0] cpm_cfg;
  logic [7:0]  pulse_cfg;
  logic [7:0]  power_on_cfg;

  step_t plan_q[$];         // requests, config writes and drain points, in order
  xfer_t expected_xfers[$]; // transfers still owed by the block
  step_t cur_req;           // request currently offered on the slave side

  int unsigned gap_left;
  int          settle_left;
  int unsigned stall_left;
  int unsigned n_reqs;
  int unsigned n_inits;
  int unsigned n_xfers;
  int unsigned n_cfg_writes;
  int unsigned n_mismatch;
  int unsigned cycle_cnt = 0;

  char_lcd_parallel_write_sequencer uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // power-up command sequence: three wake-ups, function set, display on,
  // clear, entry mode
  function automatic logic [7:0] init_cmd(input int k);
    case (k)
      3: return 8'h38;
      4: return 8'h0C;
      5: return 8'h01;
      6: return 8'h06;
      default: return 8'h30;
    endcase
  endfunction

  function automatic void apply_config(input logic [1:0] idx, input logic [19:0] val);
    case (idx)
      lcdws_pkg::CfgCyclesPerMs: cpm_cfg = val;
      lcdws_pkg::CfgPulseCycles: pulse_cfg = val[7:0];
      lcdws_pkg::CfgPowerOnMs:   power_on_cfg = val[7:0];
      default: ;  // index past the register list, no effect
    endcase
  endfunction

  // transfers owed for one accepted request
  function automatic void expand_request(input step_t r);
    xfer_t x;
    case (r.opcode)
      lcdws_pkg::OpInit: begin
        n_inits++;
        for (int k = 0; k < 7; k++) begin
          // only the first wake-up waits out the power-on delay, then 5 ms
          x.wait_before = (k == 0) ? power_on_cfg : 8'd0;
          x.rs          = 1'b0;
          x.bus         = init_cmd(k);
          x.wait_after  = (k == 0) ? 6'd5 : 6'd1;
          x.last        = (k == 6);
          expected_xfers.push_back(x);
        end
      end
      lcdws_pkg::OpWrite: begin
        x = '{wait_before: 8'd0, rs: r.is_data, bus: r.byte_value, wait_after: 6'd1,
              last: 1'b1};
        expected_xfers.push_back(x);
      end
      lcdws_pkg::OpGoto: begin
        // columns past 39 are not clipped, the address just runs on
        x.wait_before = 8'd0;
        x.rs          = 1'b0;
        x.bus         = (r.row ? lcdws_pkg::Line1Base : lcdws_pkg::Line0Base)
                        + {2'b00, r.column};
        x.wait_after  = 6'd1;
        x.last        = 1'b1;
        expected_xfers.push_back(x);
      end
      default: ;  // unused opcode is dropped without a transfer
    endcase
  endfunction

  // cycles the block may still spend holding off after its last word
  function automatic int unsigned holdoff_cycles();
    return int'(pulse_cfg) + 6 * int'(cpm_cfg) + 32;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus plan
  // ---------------------------------------------------------------------------

  function automatic void plan_req(input logic [1:0] op, input logic [7:0] bv,
                                   input logic dsel, input logic rw, input logic [5:0] col,
                                   input logic [1:0] gap);
    step_t s;
    s = '0;
    s.kind = StepReq;
    s.opcode = op;
    s.byte_value = bv;
    s.is_data = dsel;
    s.row = rw;
    s.column = col;
    s.gap = gap;
    plan_q.push_back(s);
  endfunction

  function automatic void plan_cfg(input logic [1:0] idx, input logic [19:0] val);
    step_t s;
    s = '0;
    s.kind = StepCfg;
    s.cfg_idx = idx;
    s.cfg_val = val;
    plan_q.push_back(s);
  endfunction

  // sender waits until every owed transfer is in and the block has settled
  function automatic void plan_drain();
    step_t s;
    s = '0;
    s.kind = StepDrain;
    plan_q.push_back(s);
  endfunction

  // random requests; a stretch of them goes back to back
  function automatic void plan_random(input int unsigned count, input int unsigned quiet_lo,
                                      input int unsigned quiet_hi);
    int unsigned done;
    int unsigned pick;
    logic [1:0]  op;
    logic [5:0]  col;
    logic [1:0]  gap;
    done = 0;
    while (done < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) op = lcdws_pkg::OpInit;
      else if (pick < 55) op = lcdws_pkg::OpWrite;
      else if (pick < 90) op = lcdws_pkg::OpGoto;
      else op = OpUnused;
      // mostly valid columns, some past the end of the line
      col = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(40, 63))
                                        : 6'($urandom_range(0, 39));
      gap = (done >= quiet_lo && done < quiet_hi) ? 2'd0 : 2'($urandom_range(0, 3));
      plan_req(op, 8'($urandom), 1'($urandom), 1'($urandom), col, gap);
      if (op != OpUnused) done++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // request driver
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    step_t st;
    logic  valid_n;
    logic  we_n;
    if (!rst_ni) begin
      s_valid <= 1'b0;
      s_tdata <= '0;
      s_tuser <= '0;
      cfg_we <= 1'b0;
      cfg_idx <= '0;
      cfg_data <= '0;
      gap_left = 0;
      settle_left = -1;
    end else begin
      valid_n = s_valid;
      we_n = 1'b0;
      if (s_valid && s_axis_tready_o) begin
        expand_request(cur_req);
        n_reqs++;
        valid_n = 1'b0;
      end
      if (!valid_n && plan_q.size() > 0) begin
        st = plan_q[0];
        case (st.kind)
          StepReq: begin
            if (gap_left < st.gap) begin
              gap_left++;
            end else begin
              void'(plan_q.pop_front());
              gap_left = 0;
              cur_req = st;
              valid_n = 1'b1;
              // tdata: byte_value, is_data, row, column from the lsb up
              s_tdata <= {st.column, st.row, st.is_data, st.byte_value};
              s_tuser <= st.opcode;
            end
          end
          StepCfg: begin
            void'(plan_q.pop_front());
            we_n = 1'b1;
            cfg_idx <= st.cfg_idx;
            cfg_data <= st.cfg_val;
            apply_config(st.cfg_idx, st.cfg_val);
            n_cfg_writes++;
          end
          default: begin
            // hold until nothing is owed, then let the last hold-off run out
            if (expected_xfers.size() == 0) begin
              if (settle_left < 0) begin
                settle_left = holdoff_cycles();
              end else if (settle_left == 0) begin
                void'(plan_q.pop_front());
                settle_left = -1;
              end else begin
                settle_left--;
              end
            end
          end
        endcase
      end
      s_valid <= valid_n;
      cfg_we <= we_n;
    end
  end

  // ---------------------------------------------------------------------------
  // transfer monitor and checker
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      n_mismatch++;
      if (n_mismatch <= 10)
        $display("word %0d: %s expected 0x%0h, got 0x%0h", n_xfers, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    xfer_t want;
    if (!rst_ni) begin
      m_tready <= 1'b0;
      stall_left = 1;
    end else begin
      if (m_tready && m_axis_tvalid_o) begin
        n_xfers++;
        if (expected_xfers.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("word %0d: nothing owed, got tdata 0x%0h tlast %b", n_xfers,
                     m_axis_tdata_o, m_axis_tlast_o);
        end else begin
          want = expected_xfers.pop_front();
          // tdata: wait_before, rs, bus byte, wait_after, pad from the lsb up
          check_field("wait_before_ms", 32'(want.wait_before), 32'(m_axis_tdata_o[7:0]));
          check_field("register_select", 32'(want.rs), 32'(m_axis_tdata_o[8]));
          check_field("bus_byte", 32'(want.bus), 32'(m_axis_tdata_o[16:9]));
          check_field("wait_after_ms", 32'(want.wait_after), 32'(m_axis_tdata_o[22:17]));
          check_field("pad bit", 32'd0, 32'(m_axis_tdata_o[23]));
          check_field("last_transfer", 32'(want.last), 32'(m_axis_tlast_o));
        end
        // every third block of 32 words runs without stalls
        stall_left = ((n_xfers / 32) % 3 == 1) ? 0 : $urandom_range(0, 3);
        // one long hold-off so the request side backs up
        if (n_xfers == LongHoldAt) stall_left = LongHoldCycles;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // run guard
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("timed out after %0d cycles, %0d words owed", cycle_cnt,
               expected_xfers.size());
      $display("FAIL char_lcd_parallel_write_sequencer");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // plan, reset and verdict
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned end_wait;
    cpm_cfg = lcdws_pkg::CyclesPerMsRst;
    pulse_cfg = lcdws_pkg::PulseCyclesRst;
    power_on_cfg = lcdws_pkg::PowerOnMsRst;
    n_reqs = 0;
    n_inits = 0;
    n_xfers = 0;
    n_cfg_writes = 0;
    n_mismatch = 0;

    // reset timing: slow, so only single-word requests
    plan_req(lcdws_pkg::OpWrite, 8'h41, 1'b1, 1'b0, 6'd0, 2'd0);
    plan_req(lcdws_pkg::OpGoto, 8'h00, 1'b0, 1'b1, 6'd5, 2'd1);
    plan_req(OpUnused, 8'h5A, 1'b1, 1'b0, 6'd17, 2'd0);
    plan_drain();

    // fastest timing, no power-on delay
    plan_cfg(lcdws_pkg::CfgCyclesPerMs, 20'd1);
    plan_cfg(lcdws_pkg::CfgPulseCycles, 20'd1);
    plan_cfg(lcdws_pkg::CfgPowerOnMs, 20'd0);
    plan_req(lcdws_pkg::OpInit, 8'h00, 1'b0, 1'b0, 6'd0, 2'd0);
    // unused fields all ones must not matter
    plan_req(lcdws_pkg::OpInit, 8'hFF, 1'b1, 1'b1, 6'd63, 2'd0);
    plan_req(lcdws_pkg::OpWrite, 8'h00, 1'b0, 1'b0, 6'd0, 2'd0);
    plan_req(lcdws_pkg::OpWrite, 8'hFF, 1'b1, 1'b0, 6'd0, 2'd2);
    plan_req(lcdws_pkg::OpWrite, 8'hFF, 1'b0, 1'b1, 6'd63, 2'd0);
    plan_req(lcdws_pkg::OpWrite, 8'h00, 1'b1, 1'b1, 6'd42, 2'd3);
    plan_req(lcdws_pkg::OpGoto, 8'h00, 1'b0, 1'b0, 6'd0, 2'd0);
    plan_req(lcdws_pkg::OpGoto, 8'h00, 1'b0, 1'b1, 6'd39, 2'd0);
    // columns at and past the line end
    plan_req(lcdws_pkg::OpGoto, 8'h00, 1'b0, 1'b0, 6'd40, 2'd1);
    plan_req(lcdws_pkg::OpGoto, 8'h00, 1'b0, 1'b1, 6'd63, 2'd0);
    plan_req(lcdws_pkg::OpGoto, 8'hFF, 1'b1, 1'b0, 6'd39, 2'd0);
    plan_req(OpUnused, 8'hFF, 1'b1, 1'b1, 6'd63, 2'd0);
    plan_req(OpUnused, 8'h00, 1'b0, 1'b0, 6'd0, 2'd2);
    plan_drain();

    // widest strobe, longest power-on delay, plus a write to the unused index
    plan_cfg(lcdws_pkg::CfgPulseCycles, 20'($urandom & 32'hFFF00) | 20'd255);
    plan_cfg(lcdws_pkg::CfgPowerOnMs, 20'($urandom & 32'hFFF00) | 20'd255);
    plan_cfg(lcdws_pkg::CfgCyclesPerMs, 20'd3);
    plan_cfg(CfgUnused, 20'($urandom));
    plan_req(lcdws_pkg::OpInit, 8'($urandom), 1'($urandom), 1'($urandom), 6'($urandom),
             2'd0);
    plan_req(lcdws_pkg::OpWrite, 8'($urandom), 1'($urandom), 1'($urandom), 6'($urandom),
             2'd1);
    plan_req(lcdws_pkg::OpGoto, 8'($urandom), 1'($urandom), 1'($urandom),
             6'($urandom_range(0, 39)), 2'd0);
    plan_drain();

    // random traffic, moderate timing, sender pauses once midway
    plan_cfg(lcdws_pkg::CfgCyclesPerMs, 20'd2);
    plan_cfg(lcdws_pkg::CfgPulseCycles, 20'($urandom_range(1, 16)));
    plan_cfg(lcdws_pkg::CfgPowerOnMs, 20'($urandom_range(0, 20)));
    plan_random(20, 5, 12);
    plan_drain();
    plan_random(20, 0, 0);
    plan_drain();

    // random traffic, fast clock per ms, any power-on delay
    plan_cfg(lcdws_pkg::CfgCyclesPerMs, 20'd1);
    plan_cfg(lcdws_pkg::CfgPulseCycles, 20'($urandom_range(1, 8)));
    plan_cfg(lcdws_pkg::CfgPowerOnMs, 20'($urandom));
    plan_cfg(CfgUnused, 20'($urandom));
    plan_random(40, 10, 22);
    plan_drain();

    // longest millisecond; one word, its hold-off outlasts the run
    plan_cfg(lcdws_pkg::CfgCyclesPerMs, 20'hFFFFF);
    plan_cfg(lcdws_pkg::CfgPowerOnMs, 20'd0);
    plan_req(lcdws_pkg::OpGoto, 8'($urandom), 1'($urandom), 1'($urandom),
             6'($urandom_range(0, 39)), 2'd0);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (!(plan_q.size() == 0 && !s_valid && expected_xfers.size() == 0))
      @(posedge clk_i);
    end_wait = holdoff_cycles();
    if (end_wait > EndWaitMax) end_wait = EndWaitMax;
    repeat (end_wait) @(posedge clk_i);

    if (expected_xfers.size() != 0)
      $display("%0d words never arrived", expected_xfers.size());
    $display("ran %0d requests (%0d init sequences) giving %0d bus words", n_reqs, n_inits,
             n_xfers);
    $display("over %0d register writes, strobe 1..255, power-on 0..255 ms, %0d mismatches",
             n_cfg_writes, n_mismatch);
    if (n_mismatch == 0 && expected_xfers.size() == 0) begin
      $display("PASS char_lcd_parallel_write_sequencer");
    end else begin
      $display("FAIL char_lcd_parallel_write_sequencer");
    end
    $finish;
  end

endmodule
